>>> hdl/modbus_register_server_with_speed_model_assert.svh
// Assertion macros used by the register server back end.
`ifndef MODBUS_REGISTER_SERVER_WITH_SPEED_MODEL_ASSERT_SVH
`define MODBUS_REGISTER_SERVER_WITH_SPEED_MODEL_ASSERT_SVH
`ifndef SYNTH
`define MSRV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSRV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSRV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/msrv_pkg.sv
// Types, constants and codes shared by the register server modules.
`timescale 1ns / 1ps
package msrv_pkg;

    localparam int NUM_REGS_DEF = 128;
    localparam int MAX_READ_DEF = 64;

    localparam int REG_CTRL_IN  = 0;
    localparam int REG_CTRL     = 1;
    localparam int REG_DEMAND   = 2;
    localparam int REG_SPEED    = 3;
    localparam int REG_DEADBAND = 4;
    localparam int REG_TCONST   = 5;
    localparam int REG_INTERVAL = 9;

    localparam int CTRL_ACTIVE_BIT = 1;
    localparam logic [15:0] MIN_INTERVAL  = 16'd100;
    localparam logic [15:0] IDLE_INTERVAL = 16'hFFFF;
    localparam logic [2:0]  STEP_GAIN     = 3'd6;
    localparam logic [6:0]  PCT_SCALE     = 7'd100;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;

    localparam logic [1:0] ST_READ  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_ECHO  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        REQ_READ,
        REQ_WRITE,
        REQ_ECHO,
        REQ_ERR
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [15:0] addr;
        logic [15:0] qv;
        logic [19:0] elapsed;
        logic [6:0]  rnd;
    } req_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } queue_ctl_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_R0, S_R2, S_R4, S_R5, S_SQ, S_DIVS, S_DIV1,
        S_MUL1, S_MUL2, S_DIVS2, S_DIV2, S_W3, S_W9, S_EXEC, S_RESP,
        S_RDREQ, S_RDWAIT
    } back_state_t;

endpackage

>>> hdl/msrv_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module msrv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic        done,
    output logic [31:0] quot
);
    import msrv_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg[31:0], quo_reg[31]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;
endmodule

>>> hdl/msrv_front.sv
// Request front end: range classification and a two-entry request queue.
`timescale 1ns / 1ps
module msrv_front #(
    parameter int NUM_REGS = msrv_pkg::NUM_REGS_DEF,
    parameter int MAX_READ = msrv_pkg::MAX_READ_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [15:0]          reg_addr,
    input  logic [15:0]          quantity_or_value,
    input  logic [19:0]          elapsed_ms,
    input  logic [6:0]           random_draw,
    input  msrv_pkg::queue_ctl_t ctl,
    output logic                 q_valid,
    output msrv_pkg::req_t       q_data
);
    import msrv_pkg::*;

    req_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    req_t       req_in;
    logic [16:0] end_addr;
    logic       push;
    logic       pop;

    assign end_addr = {1'b0, reg_addr} + {1'b0, quantity_or_value};

    always_comb
    begin
        req_in.addr    = reg_addr;
        req_in.qv      = quantity_or_value;
        req_in.elapsed = elapsed_ms;
        req_in.rnd     = random_draw;
        priority if (action == ACT_READ)
        begin
            if (quantity_or_value == 16'd0 || 32'(quantity_or_value) > 32'(MAX_READ)
                || 32'(end_addr) > 32'(NUM_REGS))
                req_in.kind = REQ_ERR;
            else
                req_in.kind = REQ_READ;
        end
        else if (action == ACT_WRITE)
        begin
            req_in.kind = (32'(reg_addr) >= 32'(NUM_REGS)) ? REQ_ERR : REQ_WRITE;
        end
        else
        begin
            req_in.kind = REQ_ECHO;
        end
    end

    assign in_ready = (cnt_reg != 2'd2) && !ctl.clearing;
    assign push     = in_valid && in_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign pop      = ctl.pop && q_valid;
    assign q_data   = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= req_in;
    end
endmodule

>>> hdl/msrv_back.sv
// Request back end: register file, plant step sequencer and response output.
`timescale 1ns / 1ps
`include "modbus_register_server_with_speed_model_assert.svh"
module msrv_back #(
    parameter int NUM_REGS = msrv_pkg::NUM_REGS_DEF,
    parameter int MAX_READ = msrv_pkg::MAX_READ_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  msrv_pkg::req_t       q_data,
    output msrv_pkg::queue_ctl_t ctl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          word_value,
    output logic [1:0]           status,
    output logic                 last
);
    import msrv_pkg::*;

    localparam int AW = $clog2(NUM_REGS);
    localparam int KW = $clog2(MAX_READ + 1);

    back_state_t state_reg, state_next;

    logic [15:0] mem [NUM_REGS];
    logic [15:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wa;
    logic [15:0] wd;
    logic        we;

    req_t        req_reg;
    logic [AW-1:0] clr_reg;
    logic [KW-1:0] k_reg;
    logic [15:0] speed_reg;
    logic [15:0] reg0_reg;
    logic [15:0] demand_reg;
    logic [15:0] deadband_reg;
    logic [15:0] tconst_reg;
    logic [15:0] err_reg;
    logic [31:0] sq_reg;
    logic [15:0] interval_reg;
    logic [9:0]  prod1_reg;
    logic [29:0] num_reg;
    logic [22:0] den_reg;
    logic [15:0] resp_word_reg;
    logic [1:0]  resp_status_reg;

    logic        out_valid_reg;
    logic [15:0] out_word_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    logic        div_start;
    logic [31:0] div_num;
    logic [31:0] div_den;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_quot;

    logic        load;
    logic        read_last;
    logic [16:0] rd_sum;
    logic [15:0] err_calc;
    logic [15:0] step;

    msrv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign rd_sum    = {1'b0, req_reg.addr} + 17'(k_reg);
    assign read_last = (17'(k_reg) + 17'd1) == {1'b0, req_reg.qv};
    assign load      = !out_valid_reg || out_ready;
    assign err_calc  = (speed_reg > demand_reg) ? (speed_reg - demand_reg)
                                                : (demand_reg - speed_reg);
    assign step      = div_quot[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.pop      = 1'b0;
        ctl.clearing = 1'b0;
        we           = 1'b0;
        wa           = clr_reg;
        wd           = '0;
        rd_addr      = AW'(REG_CTRL_IN);
        div_start    = 1'b0;
        div_num      = {2'b00, num_reg};
        div_den      = {9'd0, den_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clearing = 1'b1;
                we = 1'b1;
                if (32'(clr_reg) == NUM_REGS - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    ctl.pop = 1'b1;
                    state_next = S_R0;
                end
            end
            S_R0:
            begin
                we = 1'b1;
                wa = AW'(REG_CTRL);
                wd = rd_data_reg;
                rd_addr = AW'(REG_DEMAND);
                state_next = S_R2;
            end
            S_R2:
            begin
                rd_addr = AW'(REG_DEADBAND);
                state_next = S_R4;
            end
            S_R4:
            begin
                rd_addr = AW'(REG_TCONST);
                state_next = S_R5;
            end
            S_R5:    state_next = S_SQ;
            S_SQ:    state_next = S_DIVS;
            S_DIVS:
            begin
                if (err_reg > deadband_reg)
                begin
                    div_start = 1'b1;
                    div_num = {16'd0, tconst_reg};
                    div_den = sq_reg;
                    state_next = S_DIV1;
                end
                else
                    state_next = S_MUL1;
            end
            S_DIV1:
            begin
                if (div_done)
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                if (reg0_reg[CTRL_ACTIVE_BIT] && demand_reg != speed_reg)
                    state_next = S_MUL2;
                else
                    state_next = S_W3;
            end
            S_MUL2:  state_next = S_DIVS2;
            S_DIVS2:
            begin
                div_start = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                    state_next = S_W3;
            end
            S_W3:
            begin
                we = 1'b1;
                wa = AW'(REG_SPEED);
                wd = speed_reg;
                state_next = S_W9;
            end
            S_W9:
            begin
                we = 1'b1;
                wa = AW'(REG_INTERVAL);
                wd = interval_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (req_reg.kind == REQ_READ)
                    state_next = S_RDREQ;
                else
                begin
                    if (req_reg.kind == REQ_WRITE)
                    begin
                        we = 1'b1;
                        wa = req_reg.addr[AW-1:0];
                        wd = req_reg.qv;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            S_RDREQ:
            begin
                rd_addr = rd_sum[AW-1:0];
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                rd_addr = rd_sum[AW-1:0];
                if (load)
                    state_next = read_last ? S_IDLE : S_RDREQ;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (state_reg == S_DIV2 && div_done)
                speed_reg <= (demand_reg > speed_reg) ? (speed_reg + step)
                                                      : (speed_reg - step);
            if ((state_reg == S_RESP || state_reg == S_RDWAIT) && load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                req_reg <= q_data;
                k_reg   <= '0;
            end
            S_R0:   reg0_reg     <= rd_data_reg;
            S_R2:   demand_reg   <= rd_data_reg;
            S_R4:   deadband_reg <= rd_data_reg;
            S_R5:
            begin
                tconst_reg <= rd_data_reg;
                err_reg    <= err_calc;
            end
            S_SQ:   sq_reg <= 32'(err_reg) * 32'(err_reg);
            S_DIVS:
            begin
                if (!(err_reg > deadband_reg))
                    interval_reg <= IDLE_INTERVAL;
            end
            S_DIV1:
            begin
                if (div_done)
                    interval_reg <= (div_quot < 32'(MIN_INTERVAL)) ? MIN_INTERVAL
                                                                   : div_quot[15:0];
            end
            S_MUL1: prod1_reg <= 10'(req_reg.rnd) * 10'(STEP_GAIN);
            S_MUL2:
            begin
                num_reg <= 30'(prod1_reg) * 30'(req_reg.elapsed);
                den_reg <= 23'(interval_reg) * 23'(PCT_SCALE);
            end
            S_EXEC:
            begin
                unique case (req_reg.kind)
                    REQ_WRITE:
                    begin
                        resp_word_reg   <= req_reg.qv;
                        resp_status_reg <= ST_WRITE;
                    end
                    REQ_ECHO:
                    begin
                        resp_word_reg   <= '0;
                        resp_status_reg <= ST_ECHO;
                    end
                    REQ_ERR:
                    begin
                        resp_word_reg   <= '0;
                        resp_status_reg <= ST_RANGE;
                    end
                    REQ_READ:
                    begin
                        resp_word_reg   <= '0;
                        resp_status_reg <= ST_READ;
                    end
                endcase
            end
            S_RESP:
            begin
                if (load)
                begin
                    out_word_reg   <= resp_word_reg;
                    out_status_reg <= resp_status_reg;
                    out_last_reg   <= 1'b1;
                end
            end
            S_RDWAIT:
            begin
                if (load)
                begin
                    out_word_reg   <= rd_data_reg;
                    out_status_reg <= ST_READ;
                    out_last_reg   <= read_last;
                    k_reg          <= k_reg + KW'(1);
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign word_value = out_word_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    `MSRV_ASSERT_IMPL(a_clear_quiet, clk, rst_n, state_reg == S_CLEAR, !out_valid_reg)
    `MSRV_ASSERT_IMPL(a_div_free, clk, rst_n, div_start, !div_busy)
    `MSRV_ASSERT_NEXT(a_read_end, clk, rst_n,
        state_reg == S_RDWAIT && load && read_last, state_reg == S_IDLE && out_last_reg)
endmodule

>>> hdl/modbus_register_server_with_speed_model.sv
// Top level of the holding-register server with its speed plant model.
//
//  Channel   Direction  Beat contents
//  in        sink       action, reg_addr, quantity_or_value, elapsed_ms, random_draw
//  out       source     word_value, status, last
//
// Each request runs plant sequencing and dispatch through the register
// file's one read and one write port, with up to two divider passes, then
// hands over a single-result beat or, for a read, one beat per word, each
// fetched in a read-request state and then a read-wait state.
// After reset a clearing pass writes zero to all NUM_REGS words, one a cycle,
// and no input beat is taken until it ends.
// The front queue holds two requests, so input beats are taken while the
// back end waits on a stalled output beat.
`timescale 1ns / 1ps
module modbus_register_server_with_speed_model #(
    parameter int NUM_REGS = msrv_pkg::NUM_REGS_DEF,
    parameter int MAX_READ = msrv_pkg::MAX_READ_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] reg_addr,
    input  logic [15:0] quantity_or_value,
    input  logic [19:0] elapsed_ms,
    input  logic [6:0]  random_draw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] word_value,
    output logic [1:0]  status,
    output logic        last
);
    import msrv_pkg::*;

    // Requests are classified on entry, so out-of-range addresses and counts
    // reach the back end already marked as range errors.
    queue_ctl_t ctl;
    logic       q_valid;
    req_t       q_data;

    msrv_front #(
        .NUM_REGS (NUM_REGS),
        .MAX_READ (MAX_READ)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .reg_addr          (reg_addr),
        .quantity_or_value (quantity_or_value),
        .elapsed_ms        (elapsed_ms),
        .random_draw       (random_draw),
        .ctl               (ctl),
        .q_valid           (q_valid),
        .q_data            (q_data)
    );

    // The back end runs the plant step for every request before serving it.
    msrv_back #(
        .NUM_REGS (NUM_REGS),
        .MAX_READ (MAX_READ)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_value (word_value),
        .status     (status),
        .last       (last)
    );
endmodule

>>> bench/tb_modbus_register_server_with_speed_model.sv
// Self-checking testbench for the Modbus holding-register server and its speed plant.
`timescale 1ns / 1ps
module tb_modbus_register_server_with_speed_model;
    import msrv_pkg::*;

    // Request codes that the package leaves unnamed: action 2 is the
    // unsupported-code echo and action 3 is the spare code that echoes too.
    localparam logic [1:0] ACT_ECHO  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int NREGS       = NUM_REGS_DEF;
    localparam int NREAD       = MAX_READ_DEF;
    localparam int RANDOM_REQS = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN_WAIT  = 300;

    typedef struct {
        logic [15:0] word;
        logic [1:0]  st;
        logic        fin;
    } beat_t;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] addr;
        logic [15:0] qv;
        logic [19:0] el;
        logic [6:0]  rnd;
        bit          typed;
        logic [15:0] word;
        logic [1:0]  st;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [15:0] reg_addr;
    logic [15:0] quantity_or_value;
    logic [19:0] elapsed_ms;
    logic [6:0]  random_draw;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] word_value;
    logic [1:0]  status;
    logic        last;

    modbus_register_server_with_speed_model u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .reg_addr          (reg_addr),
        .quantity_or_value (quantity_or_value),
        .elapsed_ms        (elapsed_ms),
        .random_draw       (random_draw),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .word_value        (word_value),
        .status            (status),
        .last              (last)
    );

    // Shadow copy of the server state, advanced on every accepted request.
    logic [15:0] shadow_regs [NREGS];
    logic [15:0] shadow_speed;

    // Beats that the server still owes us, oldest first.
    beat_t       owed_beats [$];
    req_row_t    directed_rows [$];

    int errors = 0;
    int cycles = 0;
    int beats_seen = 0;
    int n_reads, n_writes, n_echoes, n_range;
    bit hold_request;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report(input string what);
        errors++;
        if (errors <= 30)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic owe(input logic [15:0] w, input logic [1:0] s, input logic f);
        beat_t b;
        b.word = w;
        b.st   = s;
        b.fin  = f;
        owed_beats.push_back(b);
    endtask

    // Advances the speed plant by one request period, exactly as the server does.
    task automatic plant_advance(input logic [19:0] el, input logic [6:0] rnd);
        logic [15:0] demand, deadband, tconst, interval, err, stride;
        logic [63:0] quot, num, den;
        shadow_regs[REG_CTRL] = shadow_regs[REG_CTRL_IN];
        demand   = shadow_regs[REG_DEMAND];
        deadband = shadow_regs[REG_DEADBAND];
        tconst   = shadow_regs[REG_TCONST];
        err = (shadow_speed > demand) ? shadow_speed - demand : demand - shadow_speed;
        if (err > deadband) begin
            quot = 64'(tconst) / (64'(err) * 64'(err));
            if (quot < 64'(MIN_INTERVAL))
                quot = 64'(MIN_INTERVAL);
            interval = quot[15:0];
        end
        else begin
            interval = IDLE_INTERVAL;
        end
        if (shadow_regs[REG_CTRL][CTRL_ACTIVE_BIT] && demand != shadow_speed) begin
            num    = 64'(STEP_GAIN) * 64'(rnd) * 64'(el);
            den    = 64'(interval) * 64'(PCT_SCALE);
            stride = 16'(num / den);
            if (demand > shadow_speed)
                shadow_speed = shadow_speed + stride;
            else
                shadow_speed = shadow_speed - stride;
        end
        shadow_regs[REG_SPEED]    = shadow_speed;
        shadow_regs[REG_INTERVAL] = interval;
    endtask

    // Serves one accepted request against the shadow state and queues its beats.
    task automatic serve_request(input req_row_t r);
        int cnt;
        plant_advance(r.el, r.rnd);
        if (r.act == ACT_READ) begin
            cnt = int'(r.qv);
            if (r.qv == 0 || r.qv > NREAD || int'(r.addr) + cnt > NREGS) begin
                n_range++;
                owe(16'd0, ST_RANGE, 1'b1);
            end
            else begin
                n_reads++;
                for (int k = 0; k < cnt; k++)
                    owe(shadow_regs[r.addr + k], ST_READ, k == cnt - 1);
            end
        end
        else if (r.act == ACT_WRITE) begin
            if (r.addr >= NREGS) begin
                n_range++;
                owe(16'd0, ST_RANGE, 1'b1);
            end
            else begin
                n_writes++;
                shadow_regs[r.addr] = r.qv;
                owe(r.qv, ST_WRITE, 1'b1);
            end
        end
        else begin
            n_echoes++;
            owe(16'd0, ST_ECHO, 1'b1);
        end
    endtask

    // Offers one request and holds it until the server takes it. Directed rows
    // that carry a hand-typed answer replace the predicted beat with that answer,
    // while the shadow state still advances through the predictor.
    task automatic offer(input req_row_t r);
        @(negedge clk);
        in_valid          = 1'b1;
        action            = r.act;
        reg_addr          = r.addr;
        quantity_or_value = r.qv;
        elapsed_ms        = r.el;
        random_draw       = r.rnd;
        do @(posedge clk); while (!in_ready);
        if (r.typed) begin
            serve_request(r);
            void'(owed_beats.pop_back());
            owe(r.word, r.st, 1'b1);
        end
        else begin
            serve_request(r);
        end
    endtask

    task automatic add_row(input logic [1:0] a, input logic [15:0] ad, input logic [15:0] q,
                           input logic [19:0] e, input logic [6:0] rn, input bit t,
                           input logic [15:0] w, input logic [1:0] s);
        req_row_t r;
        r.act = a; r.addr = ad; r.qv = q; r.el = e; r.rnd = rn;
        r.typed = t; r.word = w; r.st = s;
        directed_rows.push_back(r);
    endtask

    // Random request, weighted toward plant set-up writes and legal reads so
    // that the speed loop actually moves, with range errors and echoes mixed in.
    function automatic req_row_t random_request();
        req_row_t r;
        int pick;
        pick    = $urandom_range(0, 99);
        r.typed = 1'b0;
        r.word  = '0;
        r.st    = ST_READ;
        r.el    = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 5000));
        r.rnd   = 7'($urandom_range(0, 127));
        r.qv    = 16'($urandom);
        if (pick < 35) begin
            r.act = ACT_WRITE;
            case ($urandom_range(0, 3))
                0: begin
                    r.addr = 16'(REG_CTRL_IN);
                    if ($urandom_range(0, 4) != 0)
                        r.qv[CTRL_ACTIVE_BIT] = 1'b1;
                end
                1: r.addr = 16'(REG_DEMAND);
                2: begin
                    r.addr = 16'(REG_DEADBAND);
                    if ($urandom_range(0, 1) == 0)
                        r.qv = 16'($urandom_range(0, 50));
                end
                default: r.addr = 16'(REG_TCONST);
            endcase
        end
        else if (pick < 45) begin
            r.act  = ACT_WRITE;
            r.addr = 16'($urandom_range(0, NREGS - 1));
        end
        else if (pick < 80) begin
            r.act = ACT_READ;
            r.qv  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, NREAD))
                                                  : 16'($urandom_range(1, 8));
            r.addr = 16'($urandom_range(0, NREGS - r.qv));
        end
        else if (pick < 90) begin
            r.act  = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
            r.addr = 16'($urandom);
        end
        else begin
            r.act  = $urandom_range(0, 1) ? ACT_ECHO : ACT_SPARE;
            r.addr = 16'($urandom);
        end
        return r;
    endfunction

    // Cycle counter with a hard limit; a hung server ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed", cycles,
                     owed_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: out_ready steps through four patterns in turn, from
    // always ready to mostly stalled. Once, on request from the sender, it holds
    // off for a long stretch so that the server fills its queue and stalls.
    initial begin
        int mode;
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request && !held) begin
                held      = 1'b1;
                out_ready = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
            end
            mode = (cycles / 97) % 4;
            case (mode)
                0: out_ready = 1'b1;
                1: out_ready = 1'($urandom_range(0, 1));
                2: out_ready = ($urandom_range(0, 3) == 0);
                default: out_ready = (cycles % 2 == 0);
            endcase
        end
    end

    // Every output beat is compared against the oldest owed beat.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            beat_t want;
            beats_seen++;
            if (owed_beats.size() == 0) begin
                report($sformatf("unexpected beat word=%h status=%0d last=%0b",
                                 word_value, status, last));
            end
            else begin
                want = owed_beats.pop_front();
                if (word_value !== want.word)
                    report($sformatf("word_value %h, want %h", word_value, want.word));
                if (status !== want.st)
                    report($sformatf("status %0d, want %0d", status, want.st));
                if (last !== want.fin)
                    report($sformatf("last %0b, want %0b", last, want.fin));
            end
        end
    end

    initial begin
        int burst, gap;
        req_row_t r;
        n_reads = 0; n_writes = 0; n_echoes = 0; n_range = 0;
        hold_request  = 1'b0;
        shadow_speed  = '0;
        for (int k = 0; k < NREGS; k++)
            shadow_regs[k] = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        reg_addr = '0;
        quantity_or_value = '0;
        elapsed_ms = '0;
        random_draw = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: untouched register after reset, every range error,
        // both echo codes, writes at the top of the file, then plant set-up
        // with the speed loop enabled, driven by the largest elapsed time and
        // a draw above 99, a full-length read, overshoot toward a lower demand,
        // the widest deadband and finally the control bit cleared.
        add_row(ACT_READ,  16'd10,    16'd1,     20'd0,     7'd0,   1, 16'd0,     ST_READ);
        add_row(ACT_READ,  16'd0,     16'd0,     20'd1,     7'd1,   1, 16'd0,     ST_RANGE);
        add_row(ACT_READ,  16'd0,     16'd65,    20'd2,     7'd2,   1, 16'd0,     ST_RANGE);
        add_row(ACT_READ,  16'd127,   16'd2,     20'd3,     7'd3,   1, 16'd0,     ST_RANGE);
        add_row(ACT_READ,  16'hFFFF,  16'd64,    20'd4,     7'd4,   1, 16'd0,     ST_RANGE);
        add_row(ACT_READ,  16'd0,     16'hFFFF,  20'd4,     7'd4,   1, 16'd0,     ST_RANGE);
        add_row(ACT_WRITE, 16'd128,   16'h1234,  20'd5,     7'd5,   1, 16'd0,     ST_RANGE);
        add_row(ACT_WRITE, 16'hFFFF,  16'd1,     20'd6,     7'd6,   1, 16'd0,     ST_RANGE);
        add_row(ACT_WRITE, 16'd127,   16'hFFFF,  20'd7,     7'd7,   1, 16'hFFFF,  ST_WRITE);
        add_row(ACT_ECHO,  16'hFFFF,  16'hFFFF,  20'hFFFFF, 7'd127, 1, 16'd0,     ST_ECHO);
        add_row(ACT_SPARE, 16'd0,     16'd0,     20'd0,     7'd0,   1, 16'd0,     ST_ECHO);
        add_row(ACT_WRITE, 16'(REG_DEMAND),   16'd1000, 20'd0,   7'd0,   1, 16'd1000,  ST_WRITE);
        add_row(ACT_WRITE, 16'(REG_DEADBAND), 16'd5,    20'd0,   7'd0,   1, 16'd5,     ST_WRITE);
        add_row(ACT_WRITE, 16'(REG_TCONST),   16'hFFFF, 20'd0,   7'd0,   1, 16'hFFFF,  ST_WRITE);
        add_row(ACT_WRITE, 16'(REG_CTRL_IN),  16'd2,    20'd0,   7'd0,   1, 16'd2,     ST_WRITE);
        add_row(ACT_READ,  16'd0,     16'd10,    20'hFFFFF, 7'd127, 0, 16'd0,     ST_READ);
        add_row(ACT_READ,  16'd64,    16'd64,    20'hFFFFF, 7'd99,  0, 16'd0,     ST_READ);
        add_row(ACT_READ,  16'd0,     16'd64,    20'd0,     7'd0,   0, 16'd0,     ST_READ);
        add_row(ACT_WRITE, 16'(REG_DEMAND),   16'd0,    20'd500, 7'd50,  1, 16'd0,     ST_WRITE);
        add_row(ACT_READ,  16'd0,     16'd10,    20'hFFFFF, 7'd127, 0, 16'd0,     ST_READ);
        add_row(ACT_WRITE, 16'(REG_DEADBAND), 16'hFFFF, 20'd9,   7'd9,   1, 16'hFFFF,  ST_WRITE);
        add_row(ACT_READ,  16'd3,     16'd7,     20'hFFFFF, 7'd127, 0, 16'd0,     ST_READ);
        add_row(ACT_WRITE, 16'(REG_CTRL_IN),  16'hFFFD, 20'd0,   7'd0,   1, 16'hFFFD,  ST_WRITE);
        add_row(ACT_READ,  16'd0,     16'd10,    20'hAAAAA, 7'd85,  0, 16'd0,     ST_READ);

        foreach (directed_rows[i])
            offer(directed_rows[i]);

        // Random part: bursts of back-to-back beats separated by random gaps,
        // with a stretch of gap-free traffic in the middle.
        burst = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 120)
                hold_request = 1'b1;
            r = random_request();
            offer(r);
            if (burst == 0) begin
                burst = $urandom_range(1, 8);
                gap   = (n > 180 && n < 240) ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    for (int g = 1; g < gap; g++)
                        @(negedge clk);
                end
            end
            else begin
                burst--;
            end
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (owed_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d reads, %0d writes, %0d echoes and %0d range errors",
                 n_reads, n_writes, n_echoes, n_range);
        $display("%0d output beats checked in %0d cycles, %0d mismatches",
                 beats_seen, cycles, errors);
        if (errors == 0 && owed_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/msrv_pkg.sv
hdl/msrv_div.sv
hdl/msrv_front.sv
hdl/msrv_back.sv
hdl/modbus_register_server_with_speed_model.sv
bench/tb_modbus_register_server_with_speed_model.sv
